// ===== hdl/tcce_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants of the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

  localparam int STORE_DEPTH = 4096;
  localparam int RAM_AW      = $clog2(STORE_DEPTH);
  localparam int CELL_AW     = 12;
  localparam int SC_W        = 13;
  localparam int Q_DEPTH     = 2;
  localparam int QPTR_W      = $clog2(Q_DEPTH);
  localparam int QCNT_W      = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_BS         = 8'h08;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] COLOR_DEFAULT = 8'h07;

  localparam logic [7:0] COLUMNS_RESET = 8'd80;
  localparam logic [5:0] ROWS_RESET    = 6'd30;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_GOTO  = 2'd1,
    OP_READ  = 2'd2,
    OP_COLOR = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_COLUMNS = 2'd0,
    REG_ROWS    = 2'd1,
    REG_COLOR   = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_PUT,
    CMD_LF,
    CMD_BS,
    CMD_CR,
    CMD_GOTO,
    CMD_READ,
    CMD_COLOR
  } cmd_e;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_PREP,
    B_EXEC,
    B_RDWAIT,
    B_SCROLL,
    B_DONE
  } bstate_e;

  typedef struct packed {
    cmd_e       kind;
    logic [7:0] ch;
    logic [6:0] tcol;
    logic [4:0] trow;
    logic [7:0] color;
  } item_t;

  typedef struct packed {
    logic [7:0] columns;
    logic [5:0] rows;
    logic [7:0] color;
  } cfg_t;

  function automatic logic [RAM_AW-1:0] to_ram(input logic [31:0] a);
    return a[RAM_AW-1:0];
  endfunction

  function automatic logic in_store(input logic [31:0] a);
    return a < STORE_DEPTH;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/tcce_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module tcce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== hdl/tcce_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_front
// Input stage: accepts a beat, classifies it into a command and hands it on.
// ----------------------------------------------------------------------------
module tcce_front
  import tcce_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       hold_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] operation_i,
  input  wire logic [7:0] char_code_i,
  input  wire logic [6:0] column_i,
  input  wire logic [4:0] row_i,
  input  wire logic [3:0] fg_color_i,
  input  wire logic [3:0] bg_color_i,
  input  wire logic       q_full_i,
  output logic            q_push_o,
  output item_t           q_item_o
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  accept;

  function automatic cmd_e classify(input logic [1:0] op, input logic [7:0] ch);
    cmd_e k;
    k = CMD_NOP;
    case (op)
      OP_PUT: begin
        if (ch inside {[8'h20:8'hFF]}) begin
          k = CMD_PUT;
        end else if (ch == CH_LF) begin
          k = CMD_LF;
        end else if (ch == CH_BS) begin
          k = CMD_BS;
        end else if (ch == CH_CR) begin
          k = CMD_CR;
        end
      end
      OP_GOTO:  k = CMD_GOTO;
      OP_READ:  k = CMD_READ;
      OP_COLOR: k = CMD_COLOR;
      default:  k = CMD_NOP;
    endcase
    return k;
  endfunction

  assign q_push_o   = valid_q && !q_full_i;
  assign in_stall_o = hold_i || (valid_q && q_full_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign q_item_o   = item_q;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (q_push_o) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d       = 1'b1;
      item_d.kind   = classify(operation_i, char_code_i);
      item_d.ch     = char_code_i;
      item_d.tcol   = column_i;
      item_d.trow   = row_i;
      item_d.color  = {bg_color_i, fg_color_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule
`default_nettype wire

// ===== hdl/tcce_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module tcce_fifo
  import tcce_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       valid_o,
  output item_t      item_o
);

  item_t             entry_q [Q_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == QCNT_W'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = entry_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? bump(wptr_q) : wptr_q;
    rptr_d = pop_i ? bump(rptr_q) : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tcce_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_back
// Execution side: clears the cell stores after reset, carries out commands,
// walks the stores for a scroll and holds the result beat.
// ----------------------------------------------------------------------------
module tcce_back
  import tcce_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire logic       q_valid_i,
  input  wire item_t      q_item_i,
  output logic            q_pop_o,
  output logic            busy_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic      [6:0] cursor_column_o,
  output logic      [4:0] cursor_row_o,
  output logic      [7:0] cell_char_o,
  output logic      [7:0] cell_color_o,
  output logic            scrolled_o
);

  bstate_e state_q, state_d;

  logic [RAM_AW-1:0] clr_q, clr_d;
  logic [6:0]        col_q, col_d;
  logic [4:0]        line_q, line_d;
  logic              pend_v_q, pend_v_d;
  logic              ov_q, ov_d;

  item_t             item_q, item_d;
  logic [7:0]        nc_q, nc_d;
  logic [5:0]        nr_q, nr_d;
  logic [CELL_AW-1:0] addr_q, addr_d;
  logic              inside_q, inside_d;
  logic [SC_W-1:0]   moved_q, moved_d;
  logic [SC_W-1:0]   total_q, total_d;
  logic [SC_W-1:0]   sc_i_q, sc_i_d;
  logic [SC_W-1:0]   pend_dst_q, pend_dst_d;
  logic              pend_copy_q, pend_copy_d;
  logic              pend_ok_q, pend_ok_d;
  logic              rd_ok_q, rd_ok_d;
  logic [7:0]        rd_char_q, rd_char_d;
  logic [7:0]        rd_color_q, rd_color_d;
  logic              scr_q, scr_d;
  logic [6:0]        ocol_q, ocol_d;
  logic [4:0]        oline_q, oline_d;
  logic [7:0]        ochar_q, ochar_d;
  logic [7:0]        ocolor_q, ocolor_d;
  logic              oscr_q, oscr_d;

  logic              char_we, color_we;
  logic [RAM_AW-1:0] waddr, raddr;
  logic [7:0]        char_wdata, color_wdata;
  logic [7:0]        char_rdata, color_rdata;

  logic              out_free;
  logic              addr_ok;
  logic              col_wrap, line_last;
  logic [6:0]        cc;
  logic [4:0]        cl, arow;
  logic [6:0]        acol;
  logic [12:0]       aprod;
  logic [SC_W-1:0]   sc_src;

  assign out_free = !ov_q || !out_stall_i;
  assign addr_ok  = in_store(32'(addr_q));
  assign col_wrap  = ({1'b0, col_q} + 8'd1) >= nc_q;
  assign line_last = ({1'b0, line_q} + 6'd1) >= nr_q;
  assign sc_src    = sc_i_q + SC_W'(nc_q);

  assign cc   = ({1'b0, col_q} >= nc_q) ? 7'(nc_q - 8'd1) : col_q;
  assign cl   = ({1'b0, line_q} >= nr_q) ? 5'(nr_q - 6'd1) : line_q;
  assign arow = (item_q.kind == CMD_PUT) ? cl : item_q.trow;
  assign acol = (item_q.kind == CMD_PUT) ? cc : item_q.tcol;
  assign aprod = 13'(arow) * 13'(nc_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_CLEAR: begin
        if (clr_q == RAM_AW'(STORE_DEPTH - 1)) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (q_valid_i) begin
          state_d = B_PREP;
        end
      end
      B_PREP: state_d = B_EXEC;
      B_EXEC: begin
        case (item_q.kind)
          CMD_PUT:  state_d = (col_wrap && line_last) ? B_SCROLL : B_DONE;
          CMD_LF:   state_d = line_last ? B_SCROLL : B_DONE;
          CMD_READ: state_d = B_RDWAIT;
          default:  state_d = B_DONE;
        endcase
      end
      B_RDWAIT: state_d = B_DONE;
      B_SCROLL: begin
        if (sc_i_q == total_q) begin
          state_d = B_DONE;
        end
      end
      B_DONE: begin
        if (out_free) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    clr_d       = clr_q;
    col_d       = col_q;
    line_d      = line_q;
    pend_v_d    = 1'b0;
    ov_d        = ov_q && out_stall_i;
    item_d      = item_q;
    nc_d        = nc_q;
    nr_d        = nr_q;
    addr_d      = addr_q;
    inside_d    = inside_q;
    moved_d     = moved_q;
    total_d     = total_q;
    sc_i_d      = sc_i_q;
    pend_dst_d  = pend_dst_q;
    pend_copy_d = pend_copy_q;
    pend_ok_d   = pend_ok_q;
    rd_ok_d     = rd_ok_q;
    rd_char_d   = rd_char_q;
    rd_color_d  = rd_color_q;
    scr_d       = scr_q;
    ocol_d      = ocol_q;
    oline_d     = oline_q;
    ochar_d     = ochar_q;
    ocolor_d    = ocolor_q;
    oscr_d      = oscr_q;
    q_pop_o     = 1'b0;
    char_we     = 1'b0;
    color_we    = 1'b0;
    waddr       = '0;
    raddr       = '0;
    char_wdata  = CH_SPACE;
    color_wdata = COLOR_DEFAULT;

    if (pend_v_q && in_store(32'(pend_dst_q))) begin
      char_we  = 1'b1;
      color_we = 1'b1;
      waddr    = to_ram(32'(pend_dst_q));
      if (pend_copy_q) begin
        char_wdata  = pend_ok_q ? char_rdata : 8'h00;
        color_wdata = pend_ok_q ? color_rdata : 8'h00;
      end
    end

    case (state_q)
      B_CLEAR: begin
        char_we  = 1'b1;
        color_we = 1'b1;
        waddr    = clr_q;
        clr_d    = clr_q + 1'b1;
      end
      B_IDLE: begin
        if (q_valid_i) begin
          q_pop_o    = 1'b1;
          item_d     = q_item_i;
          rd_ok_d    = 1'b0;
          rd_char_d  = 8'h00;
          rd_color_d = 8'h00;
          scr_d      = 1'b0;
          if (cfg_i.columns == 8'd0) begin
            nc_d = 8'd1;
          end else if (cfg_i.columns > 8'd128) begin
            nc_d = 8'd128;
          end else begin
            nc_d = cfg_i.columns;
          end
          if (cfg_i.rows == 6'd0) begin
            nr_d = 6'd1;
          end else if (cfg_i.rows > 6'd32) begin
            nr_d = 6'd32;
          end else begin
            nr_d = cfg_i.rows;
          end
        end
      end
      B_PREP: begin
        col_d    = cc;
        line_d   = cl;
        addr_d   = CELL_AW'(aprod + 13'(acol));
        inside_d = ({1'b0, item_q.tcol} < nc_q) && ({1'b0, item_q.trow} < nr_q);
        moved_d  = SC_W'(7'(nr_q - 6'd1) * 15'(nc_q));
        total_d  = SC_W'(7'(nr_q) * 15'(nc_q));
        sc_i_d   = '0;
      end
      B_EXEC: begin
        case (item_q.kind)
          CMD_PUT: begin
            if (addr_ok) begin
              char_we     = 1'b1;
              color_we    = 1'b1;
              waddr       = to_ram(32'(addr_q));
              char_wdata  = item_q.ch;
              color_wdata = cfg_i.color;
            end
            if (col_wrap) begin
              col_d = '0;
              if (line_last) begin
                scr_d = 1'b1;
              end else begin
                line_d = line_q + 1'b1;
              end
            end else begin
              col_d = col_q + 1'b1;
            end
          end
          CMD_LF: begin
            if (line_last) begin
              scr_d = 1'b1;
            end else begin
              line_d = line_q + 1'b1;
            end
          end
          CMD_BS: begin
            if (col_q != '0) begin
              col_d = col_q - 1'b1;
            end
          end
          CMD_CR: col_d = '0;
          CMD_GOTO: begin
            if (inside_q) begin
              col_d  = item_q.tcol;
              line_d = item_q.trow;
            end
          end
          CMD_READ: begin
            raddr   = to_ram(32'(addr_q));
            rd_ok_d = inside_q && addr_ok;
          end
          CMD_COLOR: begin
            if (inside_q && addr_ok) begin
              color_we    = 1'b1;
              waddr       = to_ram(32'(addr_q));
              color_wdata = item_q.color;
            end
          end
          default: begin
          end
        endcase
      end
      B_RDWAIT: begin
        if (rd_ok_q) begin
          rd_char_d  = char_rdata;
          rd_color_d = color_rdata;
        end
      end
      B_SCROLL: begin
        if (sc_i_q != total_q) begin
          pend_v_d   = 1'b1;
          pend_dst_d = sc_i_q;
          sc_i_d     = sc_i_q + 1'b1;
          if (sc_i_q < moved_q) begin
            raddr       = to_ram(32'(sc_src));
            pend_copy_d = 1'b1;
            pend_ok_d   = in_store(32'(sc_src));
          end else begin
            pend_copy_d = 1'b0;
            pend_ok_d   = 1'b0;
          end
        end
      end
      B_DONE: begin
        if (out_free) begin
          ov_d     = 1'b1;
          ocol_d   = col_q;
          oline_d  = line_q;
          ochar_d  = rd_char_q;
          ocolor_d = rd_color_q;
          oscr_d   = scr_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_CLEAR;
      clr_q    <= '0;
      col_q    <= '0;
      line_q   <= '0;
      pend_v_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      col_q    <= col_d;
      line_q   <= line_d;
      pend_v_q <= pend_v_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    nc_q        <= nc_d;
    nr_q        <= nr_d;
    addr_q      <= addr_d;
    inside_q    <= inside_d;
    moved_q     <= moved_d;
    total_q     <= total_d;
    sc_i_q      <= sc_i_d;
    pend_dst_q  <= pend_dst_d;
    pend_copy_q <= pend_copy_d;
    pend_ok_q   <= pend_ok_d;
    rd_ok_q     <= rd_ok_d;
    rd_char_q   <= rd_char_d;
    rd_color_q  <= rd_color_d;
    scr_q       <= scr_d;
    ocol_q      <= ocol_d;
    oline_q     <= oline_d;
    ochar_q     <= ochar_d;
    ocolor_q    <= ocolor_d;
    oscr_q      <= oscr_d;
  end

  tcce_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_char_ram (
    .clk_i  (clk_i),
    .we_i   (char_we),
    .waddr_i(waddr),
    .wdata_i(char_wdata),
    .raddr_i(raddr),
    .rdata_o(char_rdata)
  );

  tcce_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_color_ram (
    .clk_i  (clk_i),
    .we_i   (color_we),
    .waddr_i(waddr),
    .wdata_i(color_wdata),
    .raddr_i(raddr),
    .rdata_o(color_rdata)
  );

  assign busy_o          = (state_q == B_CLEAR);
  assign out_valid_o     = ov_q;
  assign cursor_column_o = ocol_q;
  assign cursor_row_o    = oline_q;
  assign cell_char_o     = ochar_q;
  assign cell_color_o    = ocolor_q;
  assign scrolled_o      = oscr_q;

endmodule
`default_nettype wire

// ===== hdl/text_console_cursor_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Character-cell text console with cursor, line wrap and upward scroll.
// Items are carried out one at a time: the next item is taken from the queue
// only after the last result beat is registered. A scroll walks the stores
// one cell per cycle through the store read and write ports.
// Reset: cursor at 0,0, registers at 80 columns, 30 rows, color 0x07; a
// clearing pass fills the stores while input is stalled.
// ----------------------------------------------------------------------------
module text_console_cursor_engine
  import tcce_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [6:0]  column_i,
  input  wire logic [4:0]  row_i,
  input  wire logic [3:0]  fg_color_i,
  input  wire logic [3:0]  bg_color_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [6:0]  cursor_column_o,
  output logic      [4:0]  cursor_row_o,
  output logic      [7:0]  cell_char_o,
  output logic      [7:0]  cell_color_o,
  output logic             scrolled_o
);

  cfg_t       cfg_q, cfg_d;
  logic [1:0] reg_idx;
  logic       cfg_we;
  logic       busy;
  logic       q_full, q_push, q_pop, q_valid;
  item_t      q_in, q_out;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      case (reg_idx)
        REG_COLUMNS: cfg_d.columns = pwdata[7:0];
        REG_ROWS:    cfg_d.rows    = pwdata[5:0];
        REG_COLOR:   cfg_d.color   = pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COLUMNS: prdata = 32'(cfg_q.columns);
      REG_ROWS:    prdata = 32'(cfg_q.rows);
      REG_COLOR:   prdata = 32'(cfg_q.color);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.columns <= COLUMNS_RESET;
      cfg_q.rows    <= ROWS_RESET;
      cfg_q.color   <= COLOR_DEFAULT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tcce_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .hold_i     (busy),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .operation_i(operation_i),
    .char_code_i(char_code_i),
    .column_i   (column_i),
    .row_i      (row_i),
    .fg_color_i (fg_color_i),
    .bg_color_i (bg_color_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_in)
  );

  tcce_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (q_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .item_o (q_out)
  );

  tcce_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_valid_i      (q_valid),
    .q_item_i       (q_out),
    .q_pop_o        (q_pop),
    .busy_o         (busy),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cursor_column_o(cursor_column_o),
    .cursor_row_o   (cursor_row_o),
    .cell_char_o    (cell_char_o),
    .cell_color_o   (cell_color_o),
    .scrolled_o     (scrolled_o)
  );

endmodule
`default_nettype wire
